>>> design/pwmdiv_pkg.sv
// shared types and constants for the pwm divider solver
package pwmdiv_pkg;

   localparam int unsigned FREQ_W      = 28;
   localparam int unsigned DIVIDEND_W  = 32;
   localparam int unsigned REM_W       = FREQ_W;
   localparam int unsigned STEP_CNT_W  = $clog2(DIVIDEND_W);
   localparam int unsigned SYS_CLK_W   = 28;
   localparam int unsigned TOP_W       = 16;
   localparam int unsigned CLKDIV_W    = 12;
   localparam int unsigned WIDE_WRAP_W = TOP_W + 3;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIVIDEND_W - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_SYS_CLOCK = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_LIMIT = 8'd1;

   localparam logic [SYS_CLK_W-1:0] SYS_CLOCK_RESET = 28'd125000000;
   localparam logic [TOP_W-1:0]     TOP_LIMIT_RESET = 16'd65534;

   localparam logic [DIVIDEND_W-1:0] DIV_ONE   = 32'd16;
   localparam logic [DIVIDEND_W-1:0] DIV_MIN_5 = 32'd80;
   localparam logic [DIVIDEND_W-1:0] DIV_MIN_3 = 32'd48;
   localparam logic [DIVIDEND_W-1:0] DIV_MIN_2 = 32'd32;
   localparam logic [DIVIDEND_W-1:0] DIV_LIMIT = 32'd4096;

   // multiplicative inverses mod 2^32 for exact division
   localparam logic [DIVIDEND_W-1:0] INV_5 = 32'hCCCC_CCCD;
   localparam logic [DIVIDEND_W-1:0] INV_3 = 32'hAAAA_AAAB;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_APPLY,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      FACT_5,
      FACT_3,
      FACT_2
   } factor_type;

endpackage

>>> design/pwmdiv_serial_div.sv
// restoring serial divider, one quotient bit per cycle
module pwmdiv_serial_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pwmdiv_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [pwmdiv_pkg::FREQ_W-1:0]      divisor,
   output logic                               done,
   output logic [pwmdiv_pkg::DIVIDEND_W-1:0]  quotient
);
   import pwmdiv_pkg::*;

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [FREQ_W-1:0]       dsr_ff, dsr_in;
   logic [REM_W:0]          shifted;
   logic [REM_W:0]          diff;
   logic                    fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         rem_in = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/pwm_divider_top_solver.sv
// pwm clock divider and wrap solver, top level
//
// usage: the csr channel writes sys_clock_hz (index 0) and top_limit
// (index 1); csr_ready is always high, other indexes are ignored. write
// only while busy is low. a request transaction is taken on a rising edge
// with req_start high and busy low. the block forms 16*sys_clock_hz /
// req_wanted_freq with a serial divider (one quotient bit per cycle),
// then runs k reduction rounds (k <= 15), each a check state that
// picks factor 5, 3 or 2 and an apply state that divides exactly: by 5
// or 3 by multiplying with the inverse on one shared multiplier, by 2
// with a shift. busy stays high while a request is being solved and
// one request is in flight at a time. the response shows for one
// cycle with rsp_valid high and cannot be held off; a new request may be
// taken in that same cycle. reset restores the register defaults
// (125000000 hz, top 65534) and drops any request in flight.
module pwm_divider_top_solver (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_start,
   output logic                               busy,
   input  logic [pwmdiv_pkg::FREQ_W-1:0]      req_wanted_freq,
   output logic                               rsp_valid,
   output logic [pwmdiv_pkg::CLKDIV_W-1:0]    rsp_clock_divider,
   output logic [pwmdiv_pkg::TOP_W-1:0]       rsp_wrap_count,
   output logic                               rsp_out_of_range,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pwmdiv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwmdiv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pwmdiv_pkg::*;

   state_type               state_ff, state_in;
   factor_type              fact_ff, fact_in;
   logic [SYS_CLK_W-1:0]    sys_clk_ff;
   logic [TOP_W-1:0]        top_ff;
   logic [DIVIDEND_W-1:0]   dv_ff, dv_in;
   logic [TOP_W-1:0]        wrap_ff, wrap_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CLKDIV_W-1:0]     rsp_div_ff, rsp_div_in;
   logic [TOP_W-1:0]        rsp_wrap_ff, rsp_wrap_in;
   logic                    rsp_oor_ff, rsp_oor_in;

   logic                    accept;
   logic                    div_done;
   logic [DIVIDEND_W-1:0]   div_quotient;
   logic [6:0]              nib_sum;
   logic [4:0]              fold;
   logic [3:0]              rem15;
   logic                    by5, by3;
   logic [WIDE_WRAP_W-1:0]  wrap5, wrap3, wrap2, top_wide;
   logic [DIVIDEND_W-1:0]   inv_sel;
   logic [DIVIDEND_W-1:0]   prod;
   logic                    bad;

   assign accept    = req_start && (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   pwmdiv_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({sys_clk_ff, 4'b0000}),
      .divisor  (req_wanted_freq),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sys_clk_ff <= SYS_CLOCK_RESET;
         top_ff     <= TOP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYS_CLOCK: sys_clk_ff <= csr_wdata[SYS_CLK_W-1:0];
            CSR_TOP_LIMIT: top_ff     <= csr_wdata[TOP_W-1:0];
            default: ;
         endcase
      end
   end

   // residue mod 15 from hex digit sum, covers both 3 and 5
   always_comb begin
      nib_sum = '0;
      for (int i = 0; i < DIVIDEND_W / 4; i++) begin
         nib_sum = nib_sum + 7'(dv_ff[4*i +: 4]);
      end
      fold  = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
      rem15 = (fold >= 5'd15) ? 4'(fold - 5'd15) : fold[3:0];
      by5   = rem15 inside {4'd0, 4'd5, 4'd10};
      by3   = rem15 inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12};
   end

   always_comb begin
      top_wide = WIDE_WRAP_W'(top_ff);
      wrap2    = WIDE_WRAP_W'({wrap_ff, 1'b0});
      wrap3    = wrap2 + WIDE_WRAP_W'(wrap_ff);
      wrap5    = WIDE_WRAP_W'({wrap_ff, 2'b00}) + WIDE_WRAP_W'(wrap_ff);
      inv_sel  = (fact_ff == FACT_5) ? INV_5 : INV_3;
      prod     = dv_ff * inv_sel;
      bad      = (dv_ff < DIV_ONE) || (dv_ff >= DIV_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fact_ff     <= fact_in;
      dv_ff       <= dv_in;
      wrap_ff     <= wrap_in;
      rsp_div_ff  <= rsp_div_in;
      rsp_wrap_ff <= rsp_wrap_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   always_comb begin
      state_in     = state_ff;
      fact_in      = fact_ff;
      dv_in        = dv_ff;
      wrap_in      = wrap_ff;
      rsp_valid_in = 1'b0;
      rsp_div_in   = rsp_div_ff;
      rsp_wrap_in  = rsp_wrap_ff;
      rsp_oor_in   = rsp_oor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               dv_in    = div_quotient;
               wrap_in  = TOP_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((dv_ff >= DIV_MIN_5) && by5 && (wrap5 <= top_wide)) begin
               fact_in  = FACT_5;
               state_in = ST_APPLY;
            end else if ((dv_ff >= DIV_MIN_3) && by3 && (wrap3 <= top_wide)) begin
               fact_in  = FACT_3;
               state_in = ST_APPLY;
            end else if ((dv_ff >= DIV_MIN_2) && (wrap2 <= top_wide)) begin
               fact_in  = FACT_2;
               state_in = ST_APPLY;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_APPLY: begin
            case (fact_ff)
               FACT_5: begin
                  dv_in   = prod;
                  wrap_in = wrap5[TOP_W-1:0];
               end
               FACT_3: begin
                  dv_in   = prod;
                  wrap_in = wrap3[TOP_W-1:0];
               end
               default: begin
                  dv_in   = {1'b0, dv_ff[DIVIDEND_W-1:1]};
                  wrap_in = wrap2[TOP_W-1:0];
               end
            endcase
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_oor_in   = bad;
            rsp_div_in   = bad ? '0 : dv_ff[CLKDIV_W-1:0];
            rsp_wrap_in  = bad ? '0 : wrap_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clock_divider = rsp_div_ff;
   assign rsp_wrap_count    = rsp_wrap_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

endmodule

>>> tb/pwm_divider_top_solver_tb.sv
`timescale 1ns / 1ps
// testbench for the pwm divider solver: directed and random requests against a local predictor
module pwm_divider_top_solver_tb;
   import pwmdiv_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned TAIL_CYCLES  = 100;
   localparam int unsigned RANDOM_ITEMS = 185;
   localparam int unsigned REPORT_MAX   = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_TOP = 8'hFF;
   localparam logic [FREQ_W-1:0]      FREQ_MAX       = '1;
   localparam logic [FREQ_W-1:0]      FREQ_ONE       = FREQ_W'(1);

   typedef struct packed {
      logic [CLKDIV_W-1:0] clock_divider;
      logic [TOP_W-1:0]    wrap_count;
      logic                out_of_range;
   } solution_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_start = 1'b0;
   logic                   busy;
   logic [FREQ_W-1:0]      req_wanted_freq = '0;
   logic                   rsp_valid;
   logic [CLKDIV_W-1:0]    rsp_clock_divider;
   logic [TOP_W-1:0]       rsp_wrap_count;
   logic                   rsp_out_of_range;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [SYS_CLK_W-1:0] cfg_sys_clock = SYS_CLOCK_RESET;
   logic [TOP_W-1:0]     cfg_top_limit = TOP_LIMIT_RESET;

   solution_type pending_solutions[$];
   int unsigned  mismatches = 0;
   int unsigned  requests_sent = 0;
   int unsigned  solutions_checked = 0;
   int unsigned  out_of_range_seen = 0;
   int unsigned  register_writes = 0;
   int unsigned  idle_cycles = 0;

   pwm_divider_top_solver dut (
      .clock             (clock),
      .reset             (reset),
      .req_start         (req_start),
      .busy              (busy),
      .req_wanted_freq   (req_wanted_freq),
      .rsp_valid         (rsp_valid),
      .rsp_clock_divider (rsp_clock_divider),
      .rsp_wrap_count    (rsp_wrap_count),
      .rsp_out_of_range  (rsp_out_of_range),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic solution_type solve_pwm(logic [FREQ_W-1:0] freq);
      logic [31:0]  dv;
      logic [31:0]  wrap;
      logic [31:0]  top;
      logic         done;
      logic         bad;
      solution_type sol;
      wrap = 32'd1;
      top  = 32'(cfg_top_limit);
      done = 1'b0;
      if (freq == '0)
         dv = '1;
      else
         dv = (32'(cfg_sys_clock) * 32'd16) / 32'(freq);
      while (!done) begin
         if (dv >= 32'd80 && dv % 32'd5 == 0 && wrap * 32'd5 <= top) begin
            dv   = dv / 32'd5;
            wrap = wrap * 32'd5;
         end else if (dv >= 32'd48 && dv % 32'd3 == 0 && wrap * 32'd3 <= top) begin
            dv   = dv / 32'd3;
            wrap = wrap * 32'd3;
         end else if (dv >= 32'd32 && wrap * 32'd2 <= top) begin
            dv   = dv / 32'd2;
            wrap = wrap * 32'd2;
         end else begin
            done = 1'b1;
         end
      end
      bad = (dv < 32'd16) || (dv >= 32'd4096);
      sol.clock_divider = bad ? '0 : dv[CLKDIV_W-1:0];
      sol.wrap_count    = bad ? '0 : wrap[TOP_W-1:0];
      sol.out_of_range  = bad;
      return sol;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 80);
      else
         return $urandom_range(81, 200);
   endfunction

   function automatic logic [FREQ_W-1:0] pick_freq();
      int unsigned       r;
      longint unsigned   num;
      longint unsigned   den;
      logic [FREQ_W-1:0] f;
      r   = $urandom_range(0, 99);
      num = longint'(cfg_sys_clock) * 16;
      if (r < 30) begin
         f = FREQ_W'($urandom);
      end else if (r < 70) begin
         den = 64'd1;
         repeat ($urandom_range(0, 12)) den = den * 2;
         repeat ($urandom_range(0, 6)) den = den * 3;
         repeat ($urandom_range(0, 5)) den = den * 5;
         den = den * $urandom_range(1, 3);
         if (den > num)
            f = FREQ_ONE;
         else if (num / den > longint'(FREQ_MAX))
            f = FREQ_MAX;
         else
            f = FREQ_W'(num / den);
         if ($urandom_range(0, 3) == 0)
            f = f + 1'b1;
      end else if (r < 90) begin
         f = FREQ_W'($urandom_range(1, 20000));
      end else begin
         case ($urandom_range(0, 3))
            0: f = '0;
            1: f = FREQ_ONE;
            2: f = FREQ_MAX;
            default: f = FREQ_W'($urandom_range(2, 16));
         endcase
      end
      return f;
   endfunction

   task automatic request_freq(logic [FREQ_W-1:0] freq, int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_start       <= 1'b1;
      req_wanted_freq <= freq;
      do @(posedge clock); while (busy !== 1'b0);
      pending_solutions.push_back(solve_pwm(freq));
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_start <= 1'b0;
      while (pending_solutions.size() != 0 || busy !== 1'b0) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == CSR_SYS_CLOCK)
         cfg_sys_clock = data[SYS_CLK_W-1:0];
      else if (index == CSR_TOP_LIMIT)
         cfg_top_limit = data[TOP_W-1:0];
      register_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_freq();
      request_freq('0, 0);
      request_freq(FREQ_ONE, 0);
      request_freq(FREQ_MAX, 1);
      request_freq(28'd125000000, 0);
      request_freq(28'd125000001, 2);
      request_freq(28'd1000, 0);
      request_freq(28'd20000, 0);
      request_freq(28'd3, 5);
   endtask

   task automatic test_register_extremes();
      write_register(CSR_TOP_LIMIT, 32'hFFFF_0000);
      request_freq(28'd1000, 0);
      request_freq(28'd488281, 0);
      request_freq(28'd488282, 0);
      write_register(CSR_TOP_LIMIT, 32'd1);
      request_freq(28'd488282, 0);
      write_register(CSR_TOP_LIMIT, 32'h0000_FFFF);
      request_freq(FREQ_ONE, 0);
      write_register(CSR_SYS_CLOCK, 32'd0);
      request_freq(28'd1000, 0);
      write_register(CSR_SYS_CLOCK, 32'hFFFF_FFFF);
      request_freq(FREQ_ONE, 0);
      request_freq(FREQ_MAX, 0);
      write_register(CSR_SYS_CLOCK, 32'd1);
      request_freq(FREQ_ONE, 0);
      write_register(CSR_SYS_CLOCK, 32'hF000_0000 | 32'(SYS_CLOCK_RESET));
      write_register(CSR_UNUSED_TOP, 32'hFFFF_FFFF);
      request_freq(28'd1000, 0);
      write_register(CSR_TOP_LIMIT, 32'(TOP_LIMIT_RESET));
   endtask

   task automatic test_random_sweep();
      bit no_idle;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_SYS_CLOCK, 32'(SYS_CLOCK_RESET));
               write_register(CSR_TOP_LIMIT, 32'(TOP_LIMIT_RESET));
            end
            1: begin
               write_register(CSR_SYS_CLOCK, 32'h0FFF_FFFF);
               write_register(CSR_TOP_LIMIT, 32'h0000_FFFF);
            end
            2: begin
               write_register(CSR_SYS_CLOCK, 32'd1);
               write_register(CSR_TOP_LIMIT, 32'd1);
            end
            3: begin
               write_register(CSR_SYS_CLOCK, $urandom);
               write_register(CSR_TOP_LIMIT, $urandom);
            end
            4: begin
               write_register(CSR_SYS_CLOCK, $urandom);
               write_register(CSR_TOP_LIMIT, $urandom_range(1, 64));
            end
            5: begin
               write_register(CSR_SYS_CLOCK, $urandom_range(1, 10000));
               write_register(CSR_TOP_LIMIT, $urandom);
            end
            6: begin
               write_register(CSR_SYS_CLOCK, 32'd48000000);
               write_register(CSR_TOP_LIMIT, 32'h0000_FFFF);
            end
            default: begin
               write_register(CSR_SYS_CLOCK, $urandom);
               write_register(CSR_TOP_LIMIT, 32'd0);
            end
         endcase
         write_register(CSR_INDEX_W'($urandom_range(2, 255)), $urandom);
         no_idle = 1'b0;
         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0)
               no_idle = ($urandom_range(0, 2) == 0);
            request_freq(pick_freq(), no_idle ? 0 : pick_gap());
         end
      end
   endtask

   task automatic test_drain_pause();
      write_register(CSR_SYS_CLOCK, 32'(SYS_CLOCK_RESET));
      write_register(CSR_TOP_LIMIT, 32'(TOP_LIMIT_RESET));
      for (int burst = 0; burst < 5; burst++) begin
         for (int i = 0; i < 10; i++)
            request_freq(pick_freq(), 0);
         wait_drained();
      end
   endtask

   // compare every response transaction with the oldest prediction
   always @(posedge clock) begin
      solution_type want;
      if (!reset && rsp_valid === 1'b1) begin
         solutions_checked++;
         if (rsp_out_of_range === 1'b1)
            out_of_range_seen++;
         if (pending_solutions.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response: div %0d wrap %0d oor %0b",
                        rsp_clock_divider, rsp_wrap_count, rsp_out_of_range);
         end else begin
            want = pending_solutions.pop_front();
            if (rsp_clock_divider !== want.clock_divider ||
                rsp_wrap_count !== want.wrap_count ||
                rsp_out_of_range !== want.out_of_range) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch: expected div %0d wrap %0d oor %0b, got div %0d wrap %0d oor %0b",
                           want.clock_divider, want.wrap_count, want.out_of_range,
                           rsp_clock_divider, rsp_wrap_count, rsp_out_of_range);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed_freq();
      test_register_extremes();
      test_random_sweep();
      test_drain_pause();
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_solutions.size() != 0) begin
         mismatches++;
         $display("%0d predictions never answered", pending_solutions.size());
      end
      $display("covered %0d requests, %0d responses (%0d out of range), %0d register writes",
               requests_sent, solutions_checked, out_of_range_seen, register_writes);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
